// ===== hdl/jptp_pkg.sv =====
`timescale 1ns / 1ps
package jptp_pkg;

  localparam int POSITION_BITS_DEFAULT = 16;
  localparam int ERR_POS_BITS = 16;
  localparam int INDEX_BITS = 64;
  // result queue depth, power of two
  localparam int FIFO_DEPTH = 4;

  localparam logic [7:0] CHAR_HASH    = 8'h23;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_TILDE   = 8'h7E;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_ONE     = 8'h31;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_CR      = 8'h0D;

  typedef enum logic [1:0] {
    KIND_NAME_BYTE = 2'd0,
    KIND_TOKEN_END = 2'd1,
    KIND_WHOLE_DOC = 2'd2,
    KIND_ERROR     = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    PH_START      = 3'd0,
    PH_AFTER_HASH = 3'd1,
    PH_TOKEN      = 3'd2,
    PH_TILDE      = 3'd3,
    PH_PCT1       = 3'd4,
    PH_PCT2       = 3'd5,
    PH_SKIP       = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    NP_SPACE  = 2'd0,
    NP_SIGN   = 2'd1,
    NP_DIGITS = 2'd2,
    NP_DONE   = 2'd3
  } num_phase_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_string;
    logic       empty_string;
  } in_item_t;

  typedef struct packed {
    kind_e                   kind;
    logic [7:0]              out_byte;
    logic                    token_is_index;
    logic [INDEX_BITS-1:0]   index_value;
    logic [ERR_POS_BITS-1:0] error_position;
    logic                    last_result;
  } out_item_t;

  // queued result: index kept as magnitude plus sign, negated on the way out
  typedef struct packed {
    kind_e                   kind;
    logic [7:0]              out_byte;
    logic                    is_index;
    logic                    negative;
    logic [INDEX_BITS-1:0]   value;
    logic [ERR_POS_BITS-1:0] err_pos;
    logic                    last;
  } res_entry_t;

endpackage

// ===== hdl/jptp_if.sv =====
`timescale 1ns / 1ps
interface jptp_in_if import jptp_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface jptp_out_if import jptp_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/json_pointer_token_parser_unit.sv =====
`timescale 1ns / 1ps
// json pointer token parser: one byte item accepted per clock while the result queue has room for two results
// results enter a 4-entry queue at the accept edge and are offered from its head in order
// an item gives 0 to 2 results; the output side drains one result per cycle while ready is high,
// so items that give two results can fill the queue and hold back the input
// asynchronous active-low reset clears the parse state and empties the queue
module json_pointer_token_parser_unit import jptp_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  jptp_in_if.sink   in_i,
  jptp_out_if.source out_o
);

  localparam int EW = (POSITION_BITS > ERR_POS_BITS) ? POSITION_BITS : ERR_POS_BITS;

  // parse state
  logic                     frag_q, frag_d;
  phase_e                   phase_q, phase_d;
  logic [POSITION_BITS-1:0] offset_q, offset_d;
  logic [3:0]               hn_q, hn_d;
  num_phase_e               np_q, np_d;
  logic                     neg_q, neg_d;
  logic [INDEX_BITS-1:0]    val_q, val_d;
  logic                     ovf_q, ovf_d;
  logic                     has_q, has_d;

  logic       accept;
  logic [7:0] b;
  logic       eos, empty;

  // decode controls
  phase_e     ph_nxt;
  logic       set_frag, do_emit, te_slash, te_eos, do_fault, whole_doc, load_hn;
  logic [1:0] fault_back;
  logic [7:0] emit_val;

  logic       b_dig, b_hexa, hex_ok;
  logic [3:0] hex_val;

  // digit feed on the emitted byte
  logic                  c_dig, c_ws;
  logic [INDEX_BITS+3:0] prod;
  num_phase_e            fd_np;
  logic                  fd_neg, fd_ovf, fd_has, fd_add;
  logic [INDEX_BITS-1:0] fd_val;

  logic [EW-1:0] err_full;
  res_entry_t    r0, r1;
  logic [1:0]    wr_en;
  logic          room;
  res_entry_t    rd_data;

  assign b      = in_i.payload.byte_value;
  assign eos    = in_i.payload.end_of_string;
  assign empty  = in_i.payload.empty_string;
  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = room;

  assign b_dig   = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  assign b_hexa  = (b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_F);
  assign hex_ok  = b_dig || b_hexa;
  assign hex_val = b_dig ? b[3:0] : (b[3:0] + 4'd9);

  // decode of the parse phase against the incoming byte
  always_comb begin
    ph_nxt     = phase_q;
    set_frag   = 1'b0;
    do_emit    = 1'b0;
    te_slash   = 1'b0;
    te_eos     = 1'b0;
    do_fault   = 1'b0;
    whole_doc  = 1'b0;
    load_hn    = 1'b0;
    fault_back = 2'd0;
    emit_val   = b;
    unique case (phase_q)
      PH_START: begin
        if (b == CHAR_HASH) begin
          set_frag  = 1'b1;
          ph_nxt    = PH_AFTER_HASH;
          whole_doc = eos;
        end else if (b == CHAR_SLASH) begin
          ph_nxt = PH_TOKEN;
          te_eos = eos;
        end else begin
          do_fault = 1'b1;
        end
      end
      PH_AFTER_HASH: begin
        if (b == CHAR_SLASH) begin
          ph_nxt = PH_TOKEN;
          te_eos = eos;
        end else begin
          do_fault = 1'b1;
        end
      end
      PH_TOKEN: begin
        if (b == CHAR_SLASH) begin
          te_slash = 1'b1;
          te_eos   = eos;
        end else if (b == CHAR_TILDE) begin
          if (eos) do_fault = 1'b1;
          else ph_nxt = PH_TILDE;
        end else if ((b == CHAR_PERCENT) && frag_q) begin
          if (eos) do_fault = 1'b1;
          else ph_nxt = PH_PCT1;
        end else begin
          do_emit = 1'b1;
          te_eos  = eos;
        end
      end
      PH_TILDE: begin
        if ((b == CHAR_ZERO) || (b == CHAR_ONE)) begin
          ph_nxt   = PH_TOKEN;
          do_emit  = 1'b1;
          emit_val = (b == CHAR_ZERO) ? CHAR_TILDE : CHAR_SLASH;
          te_eos   = eos;
        end else begin
          do_fault   = 1'b1;
          fault_back = 2'd1;
        end
      end
      PH_PCT1: begin
        if (!hex_ok || eos) begin
          do_fault   = 1'b1;
          fault_back = 2'd1;
        end else begin
          load_hn = 1'b1;
          ph_nxt  = PH_PCT2;
        end
      end
      PH_PCT2: begin
        if (b == CHAR_SLASH) begin
          do_fault   = 1'b1;
          fault_back = 2'd2;
        end else if (!hex_ok) begin
          do_fault   = 1'b1;
          fault_back = 2'd1;
        end else begin
          ph_nxt   = PH_TOKEN;
          do_emit  = 1'b1;
          emit_val = {hn_q, hex_val};
          te_eos   = eos;
        end
      end
      default: begin
        ph_nxt = PH_SKIP;
      end
    endcase
    if (do_fault) ph_nxt = PH_SKIP;
  end

  // size_t style number reading over the decoded bytes
  assign c_dig = (emit_val >= CHAR_ZERO) && (emit_val <= CHAR_NINE);
  assign c_ws  = (emit_val == CHAR_SPACE) || ((emit_val >= CHAR_TAB) && (emit_val <= CHAR_CR));
  // value * 10 + digit, carry bits above the index width flag overflow
  assign prod = {1'b0, val_q, 3'b000} + {3'b000, val_q, 1'b0}
              + {(INDEX_BITS)'(0), emit_val[3:0]};

  always_comb begin
    fd_np  = np_q;
    fd_neg = neg_q;
    fd_add = 1'b0;
    unique case (np_q)
      NP_SPACE: begin
        if (c_ws) begin
          fd_np = NP_SPACE;
        end else if (emit_val == CHAR_PLUS) begin
          fd_np = NP_SIGN;
        end else if (emit_val == CHAR_MINUS) begin
          fd_neg = 1'b1;
          fd_np  = NP_SIGN;
        end else if (c_dig) begin
          fd_add = 1'b1;
          fd_np  = NP_DIGITS;
        end else begin
          fd_np = NP_DONE;
        end
      end
      NP_SIGN, NP_DIGITS: begin
        if (c_dig) begin
          fd_add = 1'b1;
          fd_np  = NP_DIGITS;
        end else begin
          fd_np = NP_DONE;
        end
      end
      default: fd_np = np_q;
    endcase
    fd_has = has_q || fd_add;
    fd_ovf = ovf_q;
    fd_val = val_q;
    if (fd_add && !ovf_q) begin
      if (prod[INDEX_BITS+3:INDEX_BITS] != '0) fd_ovf = 1'b1;
      else fd_val = prod[INDEX_BITS-1:0];
    end
  end

  assign err_full = EW'(offset_q) - EW'(fault_back);

  function automatic res_entry_t token_end(input logic has, input logic ovf, input logic neg,
                                           input logic [INDEX_BITS-1:0] val,
                                           input logic last);
    res_entry_t e;
    e          = '0;
    e.kind     = KIND_TOKEN_END;
    e.is_index = has && !ovf;
    e.negative = has && !ovf && neg;
    e.value    = (has && !ovf) ? val : '0;
    e.last     = last;
    return e;
  endfunction

  // results of the accepted item, in order
  always_comb begin
    r0    = '0;
    r1    = '0;
    wr_en = 2'b00;
    if (accept) begin
      if (empty || whole_doc) begin
        r0.kind = KIND_WHOLE_DOC;
        r0.last = 1'b1;
        wr_en   = 2'b01;
      end else if (do_fault) begin
        r0.kind    = KIND_ERROR;
        r0.err_pos = err_full[ERR_POS_BITS-1:0];
        r0.last    = 1'b1;
        wr_en      = 2'b01;
      end else if (do_emit) begin
        r0.kind     = KIND_NAME_BYTE;
        r0.out_byte = emit_val;
        r1          = token_end(fd_has, fd_ovf, fd_neg, fd_val, 1'b1);
        wr_en       = {te_eos, 1'b1};
      end else if (te_slash) begin
        r0    = token_end(has_q, ovf_q, neg_q, val_q, 1'b0);
        // the second token is the fresh empty one
        r1    = token_end(1'b0, 1'b0, 1'b0, '0, 1'b1);
        wr_en = {te_eos, 1'b1};
      end else if (te_eos) begin
        r0    = token_end(has_q, ovf_q, neg_q, val_q, 1'b1);
        wr_en = 2'b01;
      end
    end
  end

  // next state
  always_comb begin
    frag_d   = frag_q;
    phase_d  = phase_q;
    offset_d = offset_q;
    hn_d     = hn_q;
    np_d     = np_q;
    neg_d    = neg_q;
    val_d    = val_q;
    ovf_d    = ovf_q;
    has_d    = has_q;
    if (accept) begin
      if (empty || eos) begin
        frag_d   = 1'b0;
        phase_d  = PH_START;
        offset_d = '0;
        hn_d     = '0;
        np_d     = NP_SPACE;
        neg_d    = 1'b0;
        val_d    = '0;
        ovf_d    = 1'b0;
        has_d    = 1'b0;
      end else begin
        phase_d = ph_nxt;
        if (set_frag) frag_d = 1'b1;
        if (load_hn) hn_d = hex_val;
        if (offset_q != '1) offset_d = offset_q + POSITION_BITS'(1);
        if (te_slash) begin
          hn_d  = '0;
          np_d  = NP_SPACE;
          neg_d = 1'b0;
          val_d = '0;
          ovf_d = 1'b0;
          has_d = 1'b0;
        end else if (do_emit) begin
          np_d  = fd_np;
          neg_d = fd_neg;
          val_d = fd_val;
          ovf_d = fd_ovf;
          has_d = fd_has;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frag_q   <= 1'b0;
      phase_q  <= PH_START;
      offset_q <= '0;
      hn_q     <= '0;
      np_q     <= NP_SPACE;
      neg_q    <= 1'b0;
      val_q    <= '0;
      ovf_q    <= 1'b0;
      has_q    <= 1'b0;
    end else begin
      frag_q   <= frag_d;
      phase_q  <= phase_d;
      offset_q <= offset_d;
      hn_q     <= hn_d;
      np_q     <= np_d;
      neg_q    <= neg_d;
      val_q    <= val_d;
      ovf_q    <= ovf_d;
      has_q    <= has_d;
    end
  end

  jptp_result_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr0_i      (r0),
    .wr1_i      (r1),
    .room_o     (room),
    .rd_en_i    (out_o.ready),
    .rd_valid_o (out_o.valid),
    .rd_data_o  (rd_data)
  );

  always_comb begin
    out_o.payload.kind           = rd_data.kind;
    out_o.payload.out_byte       = rd_data.out_byte;
    out_o.payload.token_is_index = rd_data.is_index;
    out_o.payload.index_value    = rd_data.negative ? ('0 - rd_data.value) : rd_data.value;
    out_o.payload.error_position = rd_data.err_pos;
    out_o.payload.last_result    = rd_data.last;
  end

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.payload.kind == KIND_ERROR)) |-> out_o.payload.last_result)
    else $error("error result without last flag");

  a_name_byte_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.payload.kind == KIND_NAME_BYTE)) |-> !out_o.payload.last_result)
    else $error("name byte marked as last result");

  a_name_has_no_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.payload.token_is_index) |-> (out_o.payload.index_value == '0))
    else $error("index value set on a member name");

  a_string_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (eos || empty)) |=> ((phase_q == PH_START) && (offset_q == '0) && !frag_q))
    else $error("parse state not cleared at end of string");

  a_fault_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !empty && !eos && do_fault) |=> (phase_q == PH_SKIP))
    else $error("parser did not enter skip after a fault");

endmodule

// ===== hdl/jptp_result_fifo.sv =====
`timescale 1ns / 1ps
module jptp_result_fifo import jptp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] wr_en_i,
  input  res_entry_t wr0_i,
  input  res_entry_t wr1_i,
  output logic       room_o,
  input  logic       rd_en_i,
  output logic       rd_valid_o,
  output res_entry_t rd_data_o
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  res_entry_t     mem_q [FIFO_DEPTH];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  count_q, count_d;
  logic [1:0]     n_wr;
  logic           pop;

  assign rd_valid_o = (count_q != '0);
  assign pop        = rd_en_i && rd_valid_o;
  assign room_o     = (count_q <= CW'(FIFO_DEPTH - 2));
  assign rd_data_o  = mem_q[rd_ptr_q];

  // entry 1 is only written together with entry 0
  assign n_wr = {1'b0, wr_en_i[0]} + {1'b0, wr_en_i[1]};

  always_comb begin
    wr_ptr_d = wr_ptr_q + PW'(n_wr);
    rd_ptr_d = rd_ptr_q + PW'(pop);
    count_d  = count_q + CW'(n_wr) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i[0]) begin
      mem_q[wr_ptr_q] <= wr0_i;
    end
    if (wr_en_i[1]) begin
      mem_q[wr_ptr_q + PW'(1)] <= wr1_i;
    end
  end

endmodule

// ===== dv/tb_json_pointer_token_parser_unit.sv =====
`timescale 1ns / 1ps
module tb_json_pointer_token_parser_unit;
  import jptp_pkg::*;

  localparam int POS_BITS = POSITION_BITS_DEFAULT;
  localparam int unsigned POS_MAX = (32'd1 << POS_BITS) - 32'd1;
  localparam int STUCK_LIMIT = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  jptp_in_if  in_ch ();
  jptp_out_if out_ch ();

  json_pointer_token_parser_unit #(
    .POSITION_BITS(POS_BITS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // parser state mirrored by the predictor
  logic         in_frag;
  phase_e       phase;
  int unsigned  byte_pos;
  logic [3:0]   hi_nib;
  num_phase_e   num_ph;
  logic         num_neg;
  logic [63:0]  num_val;
  logic         num_ovf;
  logic         num_seen_digit;

  out_item_t   expected_parse_q[$];
  logic [7:0]  text_q[$];
  out_item_t   got_res;
  out_item_t   want_res;
  int          fail_count = 0;
  int          sent_items = 0;
  int          stuck_cycles = 0;
  int          stall_request = 0;
  int          stall_left = 0;
  bit          no_idle = 1'b0;

  function automatic void add_text(logic [7:0] c);
    text_q.insert(text_q.size(), c);
  endfunction

  function automatic void add_expected(out_item_t r);
    expected_parse_q.insert(expected_parse_q.size(), r);
  endfunction

  function automatic out_item_t make_res(kind_e k, logic [7:0] c, logic is_idx,
                                         logic [63:0] v, logic [15:0] p, logic last);
    out_item_t r;
    r.kind = k;
    r.out_byte = c;
    r.token_is_index = is_idx;
    r.index_value = v;
    r.error_position = p;
    r.last_result = last;
    return r;
  endfunction

  function automatic void clear_token();
    hi_nib = '0;
    num_ph = NP_SPACE;
    num_neg = 1'b0;
    num_val = '0;
    num_ovf = 1'b0;
    num_seen_digit = 1'b0;
  endfunction

  function automatic void clear_string();
    in_frag = 1'b0;
    phase = PH_START;
    byte_pos = 0;
    clear_token();
  endfunction

  function automatic void add_digit(logic [3:0] d);
    num_seen_digit = 1'b1;
    if (!num_ovf) begin
      if (num_val > (64'hFFFF_FFFF_FFFF_FFFF - 64'(d)) / 64'd10) num_ovf = 1'b1;
      else num_val = num_val * 64'd10 + 64'(d);
    end
  endfunction

  // index detection mimics reading an unsigned 64-bit number from a stream
  function automatic void feed_number(logic [7:0] c);
    logic dig;
    dig = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    case (num_ph)
      NP_SPACE: begin
        if (c == CHAR_PLUS) begin
          num_ph = NP_SIGN;
        end else if (c == CHAR_MINUS) begin
          num_neg = 1'b1;
          num_ph = NP_SIGN;
        end else if (dig) begin
          add_digit(4'(c - CHAR_ZERO));
          num_ph = NP_DIGITS;
        end else if (c != CHAR_SPACE && (c < CHAR_TAB || c > CHAR_CR)) begin
          num_ph = NP_DONE;
        end
      end
      NP_SIGN, NP_DIGITS: begin
        if (dig) begin
          add_digit(4'(c - CHAR_ZERO));
          num_ph = NP_DIGITS;
        end else begin
          num_ph = NP_DONE;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int hex_digit(logic [7:0] c);
    if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c - CHAR_ZERO);
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) return int'(c - CHAR_UPPER_A) + 10;
    return -1;
  endfunction

  function automatic out_item_t name_byte(logic [7:0] c);
    feed_number(c);
    return make_res(KIND_NAME_BYTE, c, 1'b0, '0, '0, 1'b0);
  endfunction

  function automatic out_item_t close_token();
    logic        is_idx;
    logic [63:0] v;
    is_idx = num_seen_digit && !num_ovf;
    v = '0;
    if (is_idx) v = num_neg ? 64'd0 - num_val : num_val;
    clear_token();
    return make_res(KIND_TOKEN_END, 8'h00, is_idx, v, '0, 1'b0);
  endfunction

  function automatic out_item_t raise_fault(int unsigned p);
    phase = PH_SKIP;
    return make_res(KIND_ERROR, 8'h00, 1'b0, '0, p[15:0], 1'b1);
  endfunction

  function automatic void parse_pointer_byte(in_item_t it);
    logic [7:0]  b;
    logic        eos;
    int unsigned at;
    int unsigned base;
    int          h;
    b = it.byte_value;
    eos = it.end_of_string;
    at = byte_pos;
    base = expected_parse_q.size();
    if (it.empty_string) begin
      clear_string();
      add_expected(make_res(KIND_WHOLE_DOC, 8'h00, 1'b0, '0, '0, 1'b1));
      return;
    end
    case (phase)
      PH_START: begin
        if (b == CHAR_HASH) begin
          in_frag = 1'b1;
          phase = PH_AFTER_HASH;
          if (eos) add_expected(make_res(KIND_WHOLE_DOC, 8'h00, 1'b0, '0, '0, 1'b0));
        end else if (b == CHAR_SLASH) begin
          phase = PH_TOKEN;
          if (eos) add_expected(close_token());
        end else begin
          add_expected(raise_fault(at));
        end
      end
      PH_AFTER_HASH: begin
        if (b == CHAR_SLASH) begin
          phase = PH_TOKEN;
          if (eos) add_expected(close_token());
        end else begin
          add_expected(raise_fault(at));
        end
      end
      PH_TOKEN: begin
        if (b == CHAR_SLASH) begin
          add_expected(close_token());
          if (eos) add_expected(close_token());
        end else if (b == CHAR_TILDE) begin
          if (eos) add_expected(raise_fault(at));
          else phase = PH_TILDE;
        end else if (b == CHAR_PERCENT && in_frag) begin
          if (eos) add_expected(raise_fault(at));
          else phase = PH_PCT1;
        end else begin
          add_expected(name_byte(b));
          if (eos) add_expected(close_token());
        end
      end
      PH_TILDE: begin
        if (b == CHAR_ZERO || b == CHAR_ONE) begin
          phase = PH_TOKEN;
          add_expected(name_byte(b == CHAR_ZERO ? CHAR_TILDE : CHAR_SLASH));
          if (eos) add_expected(close_token());
        end else begin
          add_expected(raise_fault(at - 1));
        end
      end
      PH_PCT1: begin
        h = hex_digit(b);
        if (h < 0 || eos) begin
          add_expected(raise_fault(at - 1));
        end else begin
          hi_nib = h[3:0];
          phase = PH_PCT2;
        end
      end
      PH_PCT2: begin
        h = hex_digit(b);
        // a slash here means the token closed early, blame the percent sign
        if (b == CHAR_SLASH) begin
          add_expected(raise_fault(at - 2));
        end else if (h < 0) begin
          add_expected(raise_fault(at - 1));
        end else begin
          phase = PH_TOKEN;
          add_expected(name_byte({hi_nib, h[3:0]}));
          if (eos) add_expected(close_token());
        end
      end
      default: phase = PH_SKIP;
    endcase
    if (eos) begin
      if (expected_parse_q.size() > base)
        expected_parse_q[expected_parse_q.size()-1].last_result = 1'b1;
      clear_string();
    end else if (byte_pos < POS_MAX) begin
      byte_pos++;
    end
  endfunction

  task automatic report_bad(string why, out_item_t want, out_item_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s: expected kind %0d byte %02h idx %0b val %0h pos %0d last %0b",
               why, want.kind, want.out_byte, want.token_is_index, want.index_value,
               want.error_position, want.last_result);
      $display("  got kind %0d byte %02h idx %0b val %0h pos %0d last %0b",
               got.kind, got.out_byte, got.token_is_index, got.index_value,
               got.error_position, got.last_result);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got_res = out_ch.payload;
      if (expected_parse_q.size() == 0) begin
        report_bad("unexpected result", '0, got_res);
      end else begin
        want_res = expected_parse_q.pop_front();
        if (got_res.kind !== want_res.kind ||
            got_res.out_byte !== want_res.out_byte ||
            got_res.token_is_index !== want_res.token_is_index ||
            got_res.index_value !== want_res.index_value ||
            got_res.error_position !== want_res.error_position ||
            got_res.last_result !== want_res.last_result)
          report_bad("result mismatch", want_res, got_res);
      end
    end
  end

  // receiver: random idling plus an occasional long hold-off
  always @(posedge clk_i) begin
    if (stall_request > 0) begin
      stall_left = stall_request;
      stall_request = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 99) < 12) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_item(in_item_t it);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 12) begin
        in_ch.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    parse_pointer_byte(it);
    sent_items++;
  endtask

  task automatic send_queued(bit with_end);
    in_item_t it;
    foreach (text_q[i]) begin
      it.byte_value = text_q[i];
      it.end_of_string = with_end && (i == text_q.size() - 1);
      it.empty_string = 1'b0;
      send_item(it);
    end
  endtask

  task automatic send_string(string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) add_text(s[i]);
    send_queued(1'b1);
  endtask

  task automatic send_empty();
    in_item_t it;
    it.byte_value = 8'($urandom_range(0, 255));
    it.end_of_string = 1'($urandom_range(0, 1));
    it.empty_string = 1'b1;
    send_item(it);
  endtask

  function automatic logic [7:0] plain_byte(bit frag);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CHAR_SLASH || c == CHAR_TILDE || (frag && c == CHAR_PERCENT));
    return c;
  endfunction

  function automatic logic [7:0] hex_char();
    int d;
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    d = $urandom_range(0, 15);
    return (d < 10) ? CHAR_ZERO + 8'(d) : CHAR_UPPER_A + 8'(d - 10);
  endfunction

  function automatic void add_token_text(bit frag);
    int          len;
    logic [63:0] v;
    string       s;
    case ($urandom_range(0, 5))
      0: begin
        repeat ($urandom_range(0, 2))
          add_text($urandom_range(0, 1) ? CHAR_SPACE
                                        : 8'($urandom_range(CHAR_TAB, CHAR_CR)));
        case ($urandom_range(0, 3))
          0: add_text(CHAR_PLUS);
          1: add_text(CHAR_MINUS);
          default: ;
        endcase
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(18, 22) : $urandom_range(0, 6);
        repeat (len) add_text(CHAR_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 2) == 0) add_text(plain_byte(frag));
      end
      1: repeat ($urandom_range(1, 6)) add_text(plain_byte(frag));
      2: repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 2))
          0: begin
            add_text(CHAR_TILDE);
            add_text(CHAR_ZERO);
          end
          1: begin
            add_text(CHAR_TILDE);
            add_text(CHAR_ONE);
          end
          default: add_text(plain_byte(frag));
        endcase
      end
      3: repeat ($urandom_range(1, 3)) begin
        if (frag) begin
          add_text(CHAR_PERCENT);
          add_text(hex_char());
          add_text(hex_char());
        end else begin
          add_text(plain_byte(frag));
        end
      end
      4: begin
        // values mostly near the 64-bit limit, a further digit may overflow
        case ($urandom_range(0, 3))
          0: v = '1;
          1: v = 64'hFFFF_FFFF_FFFF_FFFE;
          2: v = 64'd1844674407370955161;
          default: v = {$urandom, $urandom};
        endcase
        s = $sformatf("%0d", v);
        if ($urandom_range(0, 2) == 0) s = {"-", s};
        if ($urandom_range(0, 2) == 0) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
        for (int i = 0; i < s.len(); i++) add_text(s[i]);
      end
      default: ;
    endcase
  endfunction

  task automatic test_whole_document();
    send_empty();
    send_string("#");
    // string dropped midway by an empty string
    text_q.delete();
    add_text(CHAR_SLASH);
    add_text(8'h61);
    send_queued(1'b0);
    send_empty();
  endtask

  task automatic test_token_boundaries();
    send_string("//");
    text_q.delete();
    add_text(CHAR_SLASH);
    add_text(8'h00);
    add_text(8'hFF);
    send_queued(1'b1);
    send_string("/a~0~1/");
  endtask

  task automatic test_syntax_errors();
    send_string("x/a");
    send_string("#x");
    send_string("/~");
    send_string("/~2");
    send_string("#/%");
    send_string("#/%4");
    send_string("#/%G1");
    send_string("#/%4g");
    send_string("#/%4/");
  endtask

  task automatic test_fragment_decoding();
    send_string("#/%7E%2F%31/%412");
    send_string("/%41");
  endtask

  task automatic test_index_parsing();
    send_string("/ \t-12x/+/18446744073709551615/18446744073709551616/007");
  endtask

  task automatic test_output_stall();
    stall_request = 300;
    repeat (10) send_string("/~0a/1");
  endtask

  // error position beyond the low byte of the offset, sent with no idling
  task automatic test_long_string();
    text_q.delete();
    add_text(CHAR_SLASH);
    repeat (300) add_text(plain_byte(1'b0));
    add_text(CHAR_TILDE);
    no_idle = 1'b1;
    send_queued(1'b1);
    no_idle = 1'b0;
  endtask

  task automatic test_random_pointers();
    int stop_at;
    int r;
    bit frag;
    stop_at = sent_items + 270;
    while (sent_items < stop_at) begin
      text_q.delete();
      frag = ($urandom_range(0, 2) == 0);
      if (frag) add_text(CHAR_HASH);
      repeat ($urandom_range(0, 4)) begin
        add_text(CHAR_SLASH);
        add_token_text(frag);
      end
      r = $urandom_range(0, 99);
      if (r < 8 && text_q.size() > 0) begin
        text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (r < 14) begin
        text_q.insert($urandom_range(0, text_q.size()),
                      $urandom_range(0, 1) ? CHAR_TILDE : CHAR_PERCENT);
      end else if (r < 18) begin
        text_q.delete();
        repeat ($urandom_range(1, 5)) add_text(8'($urandom_range(0, 255)));
      end
      if (text_q.size() == 0) begin
        send_empty();
      end else if ($urandom_range(0, 99) < 4) begin
        send_queued(1'b0);
        send_empty();
      end else begin
        send_queued(1'b1);
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    clear_string();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_whole_document();
    test_token_boundaries();
    test_syntax_errors();
    test_fragment_decoding();
    test_index_parsing();
    test_output_stall();
    test_long_string();
    test_random_pointers();
    in_ch.valid <= 1'b0;
    while (expected_parse_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    fail_count += expected_parse_q.size();
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/jptp_pkg.sv
hdl/jptp_if.sv
hdl/jptp_result_fifo.sv
hdl/json_pointer_token_parser_unit.sv
dv/tb_json_pointer_token_parser_unit.sv
